// ===== sv/relay_pid_autotuner_unit_assert.svh =====
// Assertion macros shared by the relay autotuner RTL.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef RELAY_PID_AUTOTUNER_UNIT_ASSERT_SVH
`define RELAY_PID_AUTOTUNER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpa assertion failed");
// next-cycle implication
`define RPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpa assertion failed");
`else
`define RPA_ASSERT_NOW(lbl, ante, cons)
`define RPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/rpa_pkg.sv =====
// Types, codes and constants of the relay autotuner.
// No dependencies; used by relay_pid_autotuner_unit.
package rpa_pkg;

	// tuning phases as reported on the result item
	localparam logic [2:0] PH_STOP  = 3'd0;
	localparam logic [2:0] PH_BEGIN = 3'd1;
	localparam logic [2:0] PH_RAMP  = 3'd2;
	localparam logic [2:0] PH_HIGH  = 3'd3;
	localparam logic [2:0] PH_LOW   = 3'd4;
	localparam logic [2:0] PH_MEAS  = 3'd5;
	localparam logic [2:0] PH_CALC  = 3'd6;
	localparam logic [2:0] PH_HALT  = 3'd7;

	// configuration register indexes
	localparam logic [2:0] CFG_CENTER = 3'd0;
	localparam logic [2:0] CFG_HYST   = 3'd1;
	localparam logic [2:0] CFG_CTOL   = 3'd2;
	localparam logic [2:0] CFG_DTOL   = 3'd3;
	localparam logic [2:0] CFG_TRIM   = 3'd4;
	localparam logic [2:0] CFG_FLOOR  = 3'd5;
	localparam logic [2:0] CFG_CEIL   = 3'd6;

	// cycle counting
	localparam logic signed [5:0] STARTUP_CYCLES = 6'sd3;
	localparam logic signed [5:0] MEASURE_CYCLES = 6'sd8;
	localparam logic signed [5:0] COUNT_TOP      = 6'sd31;

	// gain coefficients, Q8.24 (0.6, 1.2 and 0.075 times 4/pi)
	localparam logic [23:0] COEF_P = 24'd12816849;
	localparam logic [24:0] COEF_I = 25'd25633698;
	localparam logic [20:0] COEF_D = 21'd1602106;
	localparam logic [9:0]  MS_PER_S = 10'd1000;
	localparam logic [17:0] DEN_D_SCALE = 18'd256000;

	// serial datapath widths
	localparam int NUM_W = 80;
	localparam int MB_W  = 40;
	localparam logic [6:0] DIV_LAST = 7'(NUM_W - 1);

	typedef struct packed {
		logic               restart;
		logic signed [15:0] sample;
		logic [31:0]        time_ms;
	} rpa_in_t;

	typedef struct packed {
		logic [15:0]        drive;
		logic               finished_ok;
		logic               gains_ready;
		logic               failed;
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic [2:0]         phase;
	} rpa_out_t;

	// serial multiply operations, run in this order
	typedef enum logic [3:0] {
		OP_DUTY, OP_STEP, OP_SN, OP_P, OP_SN2, OP_N,
		OP_K, OP_DENI, OP_I, OP_CD, OP_DEND, OP_D
	} rpa_op_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_LOAD = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_TRIM = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_OUT  = 7'b1000000
	} rpa_state_t;

endpackage

// ===== sv/relay_pid_autotuner_unit.sv =====
// Relay autotuner: bang-bang oscillation, duty trim and Ziegler-Nichols gains.
// Depends on rpa_pkg and relay_pid_autotuner_unit_assert.svh.
//
// Usage: each sample item (restart, sample, time_ms) yields exactly one result
// item (drive, status flags, stored gains, phase). Items are handled one at a
// time; sample_ready is high only while the sequencer is idle.
// An ordinary sample passes through the execute and output states on its way
// to result_valid; a new item is taken only once the sequencer is idle again.
// A sample that ends an oscillation cycle during trimming runs two bit-serial
// multiplies (duty product, trim step). The first sample in the compute phase
// runs the gain sequence on the shared bit-serial multiplier (one multiplier
// bit per cycle) and the restoring divider (one quotient bit per cycle, 80
// per gain).
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished item waits for the register to
// free up before the sequencer returns to idle.
// Configuration writes take effect at once and are meant for idle periods.
// Reset: phase begin, flags cleared, gains and drive zero, config at defaults.
`include "relay_pid_autotuner_unit_assert.svh"

module relay_pid_autotuner_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  rpa_pkg::rpa_in_t  sample_item,
	output logic              result_valid,
	input  logic              result_ready,
	output rpa_pkg::rpa_out_t result_item
);
	import rpa_pkg::*;

	// configuration
	logic signed [15:0] center_q;
	logic [14:0] hyst_q;
	logic [15:0] ctol_q, dtol_q, trim_q, floor_q, ceil_q;
	logic [30:0] ctr_prod_q;

	// sequencer and tuning state
	rpa_state_t st_q;
	rpa_op_t op_q;
	rpa_in_t in_q;
	logic [2:0] phase_q;
	logic near_q, ready_q, fail_q, done_q;
	logic signed [5:0] cnt_q;
	logic [31:0] rise_q, fall_q;
	logic [15:0] lo_q, hi_q, drive_q;
	logic signed [15:0] cmin_q, cmax_q;
	logic [21:0] sum_min_q, sum_max_q;
	logic [39:0] sum_per_q;
	logic [31:0] gain_q [3];

	// serial multiplier / divider
	logic [NUM_W-1:0] ma_q, macc_q, num_q;
	logic [MB_W-1:0] mb_q;
	logic [39:0] tmp_q;
	logic [63:0] den_q, rem_q;
	logic [31:0] q_q;
	logic big_q, nz_q;
	logic [6:0] div_cnt_q;
	rpa_out_t out_q;
	logic out_vld_q;

	// combinational helpers
	logic signed [16:0] s17, lo_thr, hi_thr, diff, span;
	logic [16:0] dmag, smag17;
	logic [15:0] smag;
	logic near, s_gt_lo, s_le_lo, s_ge_hi, meas_wrap;
	logic signed [5:0] cnt_up;
	logic [31:0] now, off_t, on_t, duty_gap;
	logic [32:0] total;
	logic duty_ok, trim_fail;
	logic [17:0] step_mag18, step18;
	logic signed [17:0] lo_new, hi_new, lo_after, hi_after;
	logic signed [15:0] cmin_base, cmax_base, cmin_n, cmax_n;
	logic signed [22:0] dsum;
	logic [22:0] dm;
	logic neg;
	logic [4:0] n5;
	logic [NUM_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	rpa_op_t op_next;
	logic [64:0] rem_sh;
	logic rem_ge, big_n;
	logic [63:0] rem_n;
	logic [32:0] q_ext, lim;
	logic [31:0] q_n, mag, gain_val;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			hyst_q   <= '0;
			ctol_q   <= '0;
			dtol_q   <= '0;
			trim_q   <= '0;
			floor_q  <= '0;
			ceil_q   <= 16'hFFFF;
			ctr_prod_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CENTER: center_q <= cfg_data;
					CFG_HYST:   hyst_q   <= cfg_data[14:0];
					CFG_CTOL:   ctol_q   <= cfg_data;
					CFG_DTOL:   dtol_q   <= cfg_data;
					CFG_TRIM:   trim_q   <= cfg_data;
					CFG_FLOOR:  floor_q  <= cfg_data;
					CFG_CEIL:   ceil_q   <= cfg_data;
					default: ;
				endcase
			end
			// near-center bound, center * tolerance; zero for a non-positive center
			ctr_prod_q <= center_q[15] ? '0 : 31'(31'(center_q[14:0]) * 31'(ctol_q));
		end
	end

	// sample compares
	always_comb begin
		now = in_q.time_ms;
		s17 = {in_q.sample[15], in_q.sample};
		lo_thr = {center_q[15], center_q} - {2'b00, hyst_q};
		hi_thr = {center_q[15], center_q} + {2'b00, hyst_q};
		s_gt_lo = s17 > lo_thr;
		s_le_lo = !s_gt_lo;
		s_ge_hi = s17 >= hi_thr;
		diff = s17 - {center_q[15], center_q};
		dmag = diff[16] ? 17'(-diff) : 17'(diff);
		near = !center_q[15] && ({dmag, 16'h0000} < {2'b00, ctr_prod_q});
		cnt_up = (cnt_q < COUNT_TOP) ? cnt_q + 6'sd1 : cnt_q;
		meas_wrap = !s_le_lo && !s_ge_hi && near_q;
		// in-cycle extremes restart at a cycle boundary, then take this sample
		cmin_base = meas_wrap ? 16'sh7FFF : cmin_q;
		cmax_base = meas_wrap ? -16'sh8000 : cmax_q;
		cmin_n = (in_q.sample < cmin_base) ? in_q.sample : cmin_base;
		cmax_n = (in_q.sample > cmax_base) ? in_q.sample : cmax_base;
	end

	// duty check and level trim
	always_comb begin
		off_t = now - fall_q;
		on_t = now - rise_q - off_t;
		total = {1'b0, on_t} + {1'b0, off_t};
		duty_gap = (on_t > off_t) ? on_t - off_t : off_t - on_t;
		duty_ok = {2'b00, duty_gap, 16'h0000} < {num_q[48:0], 1'b0};
		span = {1'b0, hi_q} - {1'b0, lo_q};
		smag17 = span[16] ? 17'(-span) : 17'(span);
		smag = smag17[15:0];
		step_mag18 = {2'b00, tmp_q[31:16]};
		step18 = span[16] ? (~step_mag18 + 18'd1) : step_mag18;
		lo_new = {2'b00, lo_q} + step18;
		hi_new = {2'b00, hi_q} - step18;
		lo_after = (on_t < off_t) ? lo_new : {2'b00, lo_q};
		hi_after = (on_t < off_t) ? {2'b00, hi_q} : hi_new;
		trim_fail = lo_after >= hi_after;
	end

	// gain operands and multiplier load
	always_comb begin
		dsum = {sum_max_q[21], sum_max_q} - {sum_min_q[21], sum_min_q};
		dm = dsum[22] ? 23'(-dsum) : 23'(dsum);
		neg = span[16] != dsum[22];
		n5 = (cnt_q < 6'sd1) ? 5'd1 : cnt_q[4:0];
		op_next = rpa_op_t'(op_q + 4'd1);
		unique case (op_q)
			OP_DUTY: begin mul_a = NUM_W'(total);  mul_b = MB_W'(dtol_q); end
			OP_STEP: begin mul_a = NUM_W'(smag);   mul_b = MB_W'(trim_q); end
			OP_SN:   begin mul_a = NUM_W'(smag);   mul_b = MB_W'(n5); end
			OP_P:    begin mul_a = NUM_W'(COEF_P); mul_b = tmp_q; end
			OP_SN2:  begin mul_a = NUM_W'(smag);   mul_b = MB_W'(n5); end
			OP_N:    begin mul_a = NUM_W'(tmp_q);  mul_b = MB_W'(n5); end
			OP_K:    begin mul_a = NUM_W'(tmp_q);  mul_b = MB_W'(MS_PER_S); end
			OP_DENI: begin mul_a = NUM_W'(dm);     mul_b = sum_per_q; end
			OP_I:    begin mul_a = NUM_W'(COEF_I); mul_b = tmp_q; end
			OP_CD:   begin mul_a = NUM_W'(COEF_D); mul_b = MB_W'(smag); end
			OP_DEND: begin mul_a = NUM_W'(dm);     mul_b = MB_W'(DEN_D_SCALE); end
			OP_D:    begin mul_a = NUM_W'(tmp_q);  mul_b = sum_per_q; end
			default: begin mul_a = '0;             mul_b = '0; end
		endcase
	end

	// restoring divider step with saturating quotient
	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		rem_ge = rem_sh >= {1'b0, den_q};
		rem_n = rem_ge ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
		lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		q_ext = {q_q, rem_ge};
		if (big_q) begin
			big_n = 1'b1;
			q_n = q_q;
		end else if (q_ext > lim) begin
			big_n = 1'b1;
			q_n = q_q;
		end else begin
			big_n = 1'b0;
			q_n = q_ext[31:0];
		end
		mag = (big_n || den_q == '0) ? lim[31:0] : q_n;
		gain_val = !nz_q ? '0 : (neg ? (~mag + 32'd1) : mag);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			op_q <= OP_DUTY;
			in_q <= '0;
			phase_q <= PH_BEGIN;
			near_q <= 1'b0;
			ready_q <= 1'b0;
			fail_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= -6'sd1;
			rise_q <= '0;
			fall_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			drive_q <= '0;
			cmin_q <= '0;
			cmax_q <= '0;
			sum_min_q <= '0;
			sum_max_q <= '0;
			sum_per_q <= '0;
			gain_q[0] <= '0;
			gain_q[1] <= '0;
			gain_q[2] <= '0;
			ma_q <= '0;
			mb_q <= '0;
			macc_q <= '0;
			num_q <= '0;
			tmp_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			q_q <= '0;
			big_q <= 1'b0;
			nz_q <= 1'b0;
			div_cnt_q <= '0;
			out_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// the output stage reloads the register itself when it hands over
			if (result_ready && st_q != S_OUT) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (sample_valid) begin
						in_q <= sample_item;
						st_q <= S_EXEC;
					end
				end
				// one phase step on the latched item
				S_EXEC: begin
					done_q <= !in_q.restart && (phase_q == PH_STOP || phase_q == PH_HALT)
						&& ready_q;
					st_q <= S_OUT;
					if (in_q.restart) begin
						near_q <= 1'b0;
						ready_q <= 1'b0;
						fail_q <= 1'b0;
						cnt_q <= -6'sd1;
						rise_q <= '0;
						fall_q <= '0;
					end
					if (in_q.restart || phase_q == PH_BEGIN) begin
						lo_q <= floor_q;
						hi_q <= ceil_q;
						cmin_q <= '0;
						cmax_q <= '0;
						sum_min_q <= '0;
						sum_max_q <= '0;
						sum_per_q <= '0;
						phase_q <= PH_RAMP;
					end else begin
						unique case (phase_q)
							PH_RAMP: begin
								if (s_gt_lo) begin
									phase_q <= PH_HIGH;
								end else begin
									drive_q <= ceil_q;
								end
							end
							PH_HIGH: begin
								drive_q <= hi_q;
								if (s_ge_hi) begin
									phase_q <= PH_LOW;
								end else if (near) begin
									near_q <= 1'b1;
								end else if (near_q) begin
									near_q <= 1'b0;
									cnt_q <= cnt_up;
									if (cnt_up >= STARTUP_CYCLES) begin
										op_q <= OP_DUTY;
										st_q <= S_LOAD;
									end else begin
										rise_q <= now;
									end
								end
							end
							PH_LOW: begin
								drive_q <= lo_q;
								if (s_le_lo) begin
									phase_q <= PH_HIGH;
								end else if (near) begin
									near_q <= 1'b1;
								end else if (near_q) begin
									near_q <= 1'b0;
									fall_q <= now;
								end
							end
							PH_MEAS: begin
								if (s_le_lo) begin
									drive_q <= hi_q;
								end else if (s_ge_hi) begin
									drive_q <= lo_q;
									near_q <= 1'b1;
								end else if (near_q) begin
									near_q <= 1'b0;
									if (!cnt_q[5]) begin
										sum_min_q <= sum_min_q + {{6{cmin_q[15]}}, cmin_q};
										sum_max_q <= sum_max_q + {{6{cmax_q[15]}}, cmax_q};
										sum_per_q <= sum_per_q + 40'(now - rise_q);
									end
									rise_q <= now;
									cnt_q <= cnt_up;
									if (cnt_up >= MEASURE_CYCLES) begin
										phase_q <= PH_CALC;
									end
								end
								cmin_q <= cmin_n;
								cmax_q <= cmax_n;
							end
							PH_CALC: begin
								op_q <= OP_SN;
								st_q <= S_LOAD;
							end
							default: ;
						endcase
					end
				end
				S_LOAD: begin
					ma_q <= mul_a;
					mb_q <= mul_b;
					macc_q <= '0;
					st_q <= S_MUL;
				end
				// shift-add, one multiplier bit per cycle
				S_MUL: begin
					if (mb_q != '0) begin
						if (mb_q[0]) begin
							macc_q <= macc_q + ma_q;
						end
						ma_q <= ma_q << 1;
						mb_q <= mb_q >> 1;
					end else begin
						unique case (op_q)
							OP_DUTY: begin
								num_q <= macc_q;
								op_q <= OP_STEP;
								st_q <= S_LOAD;
							end
							OP_STEP: begin
								tmp_q <= macc_q[39:0];
								st_q <= S_TRIM;
							end
							OP_P: begin
								num_q <= macc_q;
								nz_q <= |macc_q;
								den_q <= {33'b0, dm, 8'h00};
								st_q <= S_DIV;
							end
							OP_I: begin
								num_q <= macc_q >> 8;
								nz_q <= |macc_q[NUM_W-1:8];
								st_q <= S_DIV;
							end
							OP_D: begin
								num_q <= macc_q;
								nz_q <= |macc_q;
								st_q <= S_DIV;
							end
							OP_DENI, OP_DEND: begin
								den_q <= macc_q[63:0];
								op_q <= op_next;
								st_q <= S_LOAD;
							end
							default: begin
								tmp_q <= macc_q[39:0];
								op_q <= op_next;
								st_q <= S_LOAD;
							end
						endcase
						rem_q <= '0;
						q_q <= '0;
						big_q <= 1'b0;
						div_cnt_q <= DIV_LAST;
					end
				end
				// apply the duty verdict
				S_TRIM: begin
					rise_q <= now;
					if (duty_ok) begin
						cnt_q <= -6'sd1;
						phase_q <= PH_MEAS;
					end else begin
						if (on_t < off_t) begin
							lo_q <= lo_new[15:0];
						end else begin
							hi_q <= hi_new[15:0];
						end
						if (trim_fail) begin
							fail_q <= 1'b1;
							phase_q <= PH_STOP;
						end
					end
					st_q <= S_OUT;
				end
				// one quotient bit per cycle
				S_DIV: begin
					num_q <= num_q << 1;
					rem_q <= rem_n;
					q_q <= q_n;
					big_q <= big_n;
					div_cnt_q <= div_cnt_q - 7'd1;
					if (div_cnt_q == '0) begin
						unique case (op_q)
							OP_P:    gain_q[0] <= gain_val;
							OP_I:    gain_q[1] <= gain_val;
							default: gain_q[2] <= gain_val;
						endcase
						if (op_q == OP_D) begin
							ready_q <= 1'b1;
							phase_q <= PH_STOP;
							st_q <= S_OUT;
						end else begin
							op_q <= op_next;
							st_q <= S_LOAD;
						end
					end
				end
				S_OUT: begin
					if (!out_vld_q || result_ready) begin
						out_q.drive <= drive_q;
						out_q.finished_ok <= done_q;
						out_q.gains_ready <= ready_q;
						out_q.failed <= fail_q;
						out_q.gain_p <= gain_q[0];
						out_q.gain_i <= gain_q[1];
						out_q.gain_d <= gain_q[2];
						out_q.phase <= phase_q;
						out_vld_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign sample_ready = (st_q == S_IDLE);
	assign result_valid = out_vld_q;
	assign result_item = out_q;

	// checks
	`RPA_ASSERT_NEXT(a_accept_exec, sample_valid && sample_ready, st_q == S_EXEC)
	`RPA_ASSERT_NOW(a_ready_stopped, ready_q, phase_q == PH_STOP)
	`RPA_ASSERT_NOW(a_fail_stopped, fail_q, phase_q == PH_STOP)
	`RPA_ASSERT_NOW(a_trim_in_high, st_q == S_TRIM, phase_q == PH_HIGH)
	`RPA_ASSERT_NOW(a_cnt_floor, st_q != S_EXEC, cnt_q >= -6'sd1)

endmodule

// ===== tb/tb_relay_pid_autotuner_unit.sv =====
// Self-checking testbench for relay_pid_autotuner_unit: relay oscillation, duty trim,
// gain computation. Depends on rpa_pkg and the RTL; a behavioral predictor checks every result.
module tb_relay_pid_autotuner_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rpa_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = CFG_CENTER;
	logic [15:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	rpa_in_t sample_item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	rpa_out_t result_item;

	relay_pid_autotuner_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample_item(sample_item),
		.result_valid(result_valid), .result_ready(result_ready), .result_item(result_item)
	);

	rpa_out_t expected_results[$];
	int n_err = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	// predictor copy of the configuration
	int tune_center = 0;
	int tune_hyst = 0;
	int tune_ctol = 0;
	int tune_dtol = 0;
	int tune_trim = 0;
	int tune_floor = 0;
	int tune_ceil = 65535;

	// predictor copy of the tuning state
	logic [2:0] tune_phase = PH_BEGIN;
	bit near_flag = 0;
	bit gains_ok = 0;
	bit tune_failed = 0;
	int cyc_cnt = -1;
	bit [31:0] t_rise = '0;
	bit [31:0] t_fall = '0;
	int lvl_lo = 0;
	int lvl_hi = 0;
	int cyc_min = 0;
	int cyc_max = 0;
	longint acc_min = 0;
	longint acc_max = 0;
	longint unsigned acc_period = 0;
	bit [15:0] drive_out = '0;
	logic signed [31:0] gain_reg [3] = '{0, 0, 0};

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void restart_tune();
		tune_phase = PH_BEGIN;
		near_flag = 0;
		gains_ok = 0;
		tune_failed = 0;
		cyc_cnt = -1;
		t_rise = '0;
		t_fall = '0;
	endfunction

	function automatic void bump_count();
		if (cyc_cnt < 31) cyc_cnt++;
	endfunction

	function automatic bit is_near(int s);
		longint d;
		d = longint'(s) - tune_center;
		if (d < 0) d = -d;
		return d * 65536 < longint'(tune_center) * longint'(tune_ctol);
	endfunction

	// exact truncated quotient, saturated to 32-bit signed
	function automatic logic signed [31:0] sat_quot(logic [127:0] num, logic [127:0] den,
			bit neg);
		logic [127:0] lim;
		logic [127:0] q;
		lim = neg ? 128'd2147483648 : 128'd2147483647;
		if (num == 0) return 0;
		if (den == 0) q = lim;
		else q = num / den;
		if (q > lim) q = lim;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	// 1 while the duty is still out of tolerance and the levels were trimmed
	function automatic bit trim_levels(bit [31:0] now);
		bit [31:0] off_t;
		bit [31:0] on_t;
		longint unsigned total;
		longint unsigned gap;
		int span;
		longint unsigned smag;
		int step_sz;
		off_t = now - t_fall;
		on_t = now - t_rise - off_t;
		total = longint'(on_t) + longint'(off_t);
		gap = (on_t > off_t) ? longint'(on_t - off_t) : longint'(off_t - on_t);
		span = lvl_hi - lvl_lo;
		smag = span < 0 ? -longint'(span) : longint'(span);
		step_sz = int'((smag * tune_trim) >> 16);
		if (span < 0) step_sz = -step_sz;
		if (gap * 65536 < longint'(tune_dtol) * 2 * total) return 0;
		if (on_t < off_t) lvl_lo += step_sz;
		else lvl_hi -= step_sz;
		if (lvl_lo >= lvl_hi) begin
			tune_failed = 1;
			tune_phase = PH_STOP;
		end
		return 1;
	endfunction

	function automatic void zn_gains();
		logic [127:0] n;
		logic [127:0] sm;
		logic [127:0] dm;
		longint span;
		longint dsum;
		bit neg;
		n = (cyc_cnt < 1) ? 1 : cyc_cnt;
		span = longint'(lvl_hi) - lvl_lo;
		dsum = acc_max - acc_min;
		sm = span < 0 ? -span : span;
		dm = dsum < 0 ? -dsum : dsum;
		neg = (span < 0) != (dsum < 0);
		gain_reg[0] = sat_quot(128'(COEF_P) * sm * n, dm * 256, neg);
		gain_reg[1] = sat_quot((128'(COEF_I) * sm * n * n * 1000) >> 8,
			dm * 128'(acc_period), neg);
		gain_reg[2] = sat_quot(128'(COEF_D) * sm * 128'(acc_period), dm * 256000, neg);
		gains_ok = 1;
	endfunction

	// expected result of one sample item
	function automatic rpa_out_t autotune_step(rpa_in_t it);
		rpa_out_t r;
		int s;
		bit [31:0] now;
		int lo_thr;
		int hi_thr;
		bit done_ok;
		s = it.sample;
		now = it.time_ms;
		lo_thr = tune_center - tune_hyst;
		hi_thr = tune_center + tune_hyst;
		if (it.restart) restart_tune();
		done_ok = (tune_phase == PH_STOP || tune_phase == PH_HALT) && gains_ok;
		case (tune_phase)
			PH_BEGIN: begin
				lvl_lo = tune_floor;
				lvl_hi = tune_ceil;
				cyc_min = 0;
				cyc_max = 0;
				acc_min = 0;
				acc_max = 0;
				acc_period = 0;
				tune_phase = PH_RAMP;
			end
			PH_RAMP: begin
				if (s > lo_thr) tune_phase = PH_HIGH;
				else drive_out = tune_ceil[15:0];
			end
			PH_HIGH: begin
				drive_out = lvl_hi[15:0];
				if (s >= hi_thr) tune_phase = PH_LOW;
				else if (is_near(s)) near_flag = 1;
				else if (near_flag) begin
					near_flag = 0;
					bump_count();
					if (cyc_cnt >= 3 && !trim_levels(now)) begin
						cyc_cnt = -1;
						tune_phase = PH_MEAS;
					end
					t_rise = now;
				end
			end
			PH_LOW: begin
				drive_out = lvl_lo[15:0];
				if (s <= lo_thr) tune_phase = PH_HIGH;
				else if (is_near(s)) near_flag = 1;
				else if (near_flag) begin
					near_flag = 0;
					t_fall = now;
				end
			end
			PH_MEAS: begin
				if (s <= lo_thr) drive_out = lvl_hi[15:0];
				else if (s >= hi_thr) begin
					drive_out = lvl_lo[15:0];
					near_flag = 1;
				end else if (near_flag) begin
					near_flag = 0;
					if (cyc_cnt >= 0) begin
						acc_min += cyc_min;
						acc_max += cyc_max;
						acc_period += longint'(now - t_rise);
					end
					cyc_min = 32767;
					cyc_max = -32768;
					t_rise = now;
					bump_count();
					if (cyc_cnt >= 8) tune_phase = PH_CALC;
				end
				if (s > cyc_max) cyc_max = s;
				if (s < cyc_min) cyc_min = s;
			end
			PH_CALC: begin
				zn_gains();
				tune_phase = PH_STOP;
			end
			default: ;
		endcase
		r.drive = drive_out;
		r.finished_ok = done_ok;
		r.gains_ready = gains_ok;
		r.failed = tune_failed;
		r.gain_p = gain_reg[0];
		r.gain_i = gain_reg[1];
		r.gain_d = gain_reg[2];
		r.phase = tune_phase;
		return r;
	endfunction

	task automatic cmp_field(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			n_err++;
			if (n_err <= 10) $display("mismatch %s: expected %h got %h", nm, e, a);
		end
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		rpa_out_t e;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("mismatch: result with no item outstanding");
			end else begin
				e = expected_results.pop_front();
				cmp_field("drive", e.drive, result_item.drive);
				cmp_field("finished_ok", e.finished_ok, result_item.finished_ok);
				cmp_field("gains_ready", e.gains_ready, result_item.gains_ready);
				cmp_field("failed", e.failed, result_item.failed);
				cmp_field("gain_p", e.gain_p, result_item.gain_p);
				cmp_field("gain_i", e.gain_i, result_item.gain_i);
				cmp_field("gain_d", e.gain_d, result_item.gain_d);
				cmp_field("phase", e.phase, result_item.phase);
			end
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n) result_ready <= 1'b0;
		else if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_sample(rpa_in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= it;
		do @(posedge clk); while (!sample_ready);
		expected_results.push_back(autotune_step(it));
	endtask

	task automatic send_fields(bit rs, int s, bit [31:0] t);
		rpa_in_t it;
		it.restart = rs;
		it.sample = s[15:0];
		it.time_ms = t;
		send_sample(it);
	endtask

	// sender pauses until every result is back and the block has settled
	task automatic wait_quiet();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CENTER: tune_center = $signed(val[15:0]);
			CFG_HYST: tune_hyst = val[14:0];
			CFG_CTOL: tune_ctol = val[15:0];
			CFG_DTOL: tune_dtol = val[15:0];
			CFG_TRIM: tune_trim = val[15:0];
			CFG_FLOOR: tune_floor = val[15:0];
			CFG_CEIL: tune_ceil = val[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(int ctr, int hy, int ct, int dt, int tr, int fl, int ce);
		wait_quiet();
		write_reg(CFG_CENTER, ctr);
		write_reg(CFG_HYST, hy);
		write_reg(CFG_CTOL, ct);
		write_reg(CFG_DTOL, dt);
		write_reg(CFG_TRIM, tr);
		write_reg(CFG_FLOOR, fl);
		write_reg(CFG_CEIL, ce);
	endtask

	// field extremes, defaults after reset, restart in the ramp and high phases
	task automatic test_directed();
		bit [31:0] t;
		t = 32'hFFFF_FFF0;
		send_fields(0, -32768, 0);
		send_fields(0, 32767, 32'hFFFF_FFFF);
		send_fields(1, 0, 32'h5555_5555);
		send_fields(0, 1, 32'hAAAA_AAAA);
		send_fields(0, -1, 32'h0000_0001);
		configure(32767, 0, 65535, 0, 0, 0, 65535);
		send_fields(1, -32768, t);
		send_fields(0, 32767, t + 5);
		send_fields(0, 32767, t + 9);
		send_fields(0, 32000, t + 20);
		send_fields(0, -32768, t + 33);
		send_fields(0, 32767, t + 40);
		send_fields(1, 0, t + 41);
		configure(-32768, 32767, 65535, 32768, 65535, 65535, 0);
		send_fields(1, 100, 7);
		send_fields(0, -32768, 8);
		send_fields(0, 0, 9);
		send_fields(0, 32767, 10);
		send_fields(0, -32768, 11);
		send_fields(0, -5, 12);
		send_fields(0, 0, 13);
	endtask

	// triangle oscillation with random steps, occasional noise and restarts
	task automatic test_oscillation(int n_items, int ctr, int amp);
		int s;
		bit up;
		int up_step;
		int dn_step;
		bit [31:0] t;
		t = $urandom();
		s = ctr - amp;
		up = 1;
		up_step = $urandom_range(amp / 3 + 1, amp / 8 + 1);
		dn_step = $urandom_range(amp / 3 + 1, amp / 8 + 1);
		send_fields(1, s, t);
		for (int i = 0; i < n_items; i++) begin
			s = up ? s + up_step : s - dn_step;
			if (s >= ctr + amp) up = 0;
			if (s <= ctr - amp) up = 1;
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			t += $urandom_range(50, 1);
			if ($urandom_range(39) == 0) send_fields(0, $urandom_range(65535), t);
			else send_fields($urandom_range(249) == 0, s, t);
		end
	endtask

	task automatic osc_phase(int n_items);
		int ctr;
		ctr = $urandom_range(20000, 2000);
		configure(ctr, $urandom_range(ctr / 6, ctr / 20), $urandom_range(9000, 3000),
			($urandom_range(2) == 0) ? 32768 : $urandom_range(20000, 2000),
			$urandom_range(20000), $urandom_range(30000), $urandom_range(65535, 35000));
		test_oscillation(n_items, ctr, $urandom_range(ctr / 2, ctr / 4));
	endtask

	// receiver stops long enough for the block to stall its input
	task automatic test_backpressure();
		hold_request = 400;
		for (int i = 0; i < 30; i++) send_fields(0, $urandom_range(65535), $urandom());
	endtask

	task automatic test_noise(int n_items);
		for (int i = 0; i < n_items; i++)
			send_fields($urandom_range(15) == 0, $urandom_range(65535), $urandom());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 16;
		recv_idle_pct = 80;
		test_directed();
		osc_phase(130);
		osc_phase(130);
		wait_quiet();
		send_idle_pct = 80;
		recv_idle_pct = 16;
		osc_phase(130);
		test_backpressure();
		wait_quiet();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		osc_phase(130);
		configure(0, 32767, 0, 0, 65535, 65535, 0);
		test_noise(60);
		configure($urandom_range(65535), $urandom_range(32767), $urandom_range(65535),
			$urandom_range(32768), $urandom_range(65535), $urandom_range(65535),
			$urandom_range(65535));
		test_noise(40);
		wait_quiet();
		if (n_err == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
